### rtl/slpf_pkg.sv
`timescale 1ns / 1ps
// slpf_pkg: shared constants, record flag type and width helper for the peak finder
// used by every rtl file of the block, depends on nothing

package slpf_pkg;

	localparam int MAX_COLS_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_W           = 11;
	localparam int CFG_ADDR_W      = 1;
	localparam int ROW_W           = 10;
	localparam int POS_W           = 10;
	localparam int ROWS_LIMIT      = 1024;
	localparam int REC_Q_DEPTH     = 4;
	localparam int REC_Q_CNT_W     = $clog2(REC_Q_DEPTH + 1);
	localparam int RES_Q_DEPTH     = 2;
	localparam int RES_Q_CNT_W     = $clog2(RES_Q_DEPTH + 1);
	localparam int RES_W           = 1 + ROW_W + POS_W;

	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COLS = 1'b1;

	typedef struct packed {
		logic first;
		logic last;
		logic frame_end;
		logic top_low;
		logic bot_low;
	} rec_flags_t;

	localparam int REC_FLAGS_W = $bits(rec_flags_t);

	function automatic int idx_w(input int n);
		idx_w = (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

### rtl/slpf_fifo.sv
`timescale 1ns / 1ps
// slpf_fifo: small show-ahead queue, used between front and back and for results
// depends on slpf_pkg for default sizes

module slpf_fifo #(
	parameter int WIDTH = slpf_pkg::RES_W,
	parameter int DEPTH = slpf_pkg::RES_Q_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           pop,
	input  logic [WIDTH-1:0]               wdata,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH + 1)-1:0]   count
);
	import slpf_pkg::*;

	localparam int PTR_W = idx_w(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign empty  = (count_q == '0);
	assign count  = count_q;
	assign do_pop = pop && !empty;
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PTR_W'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				if (rd_ptr_q == PTR_W'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/slpf_front.sv
`timescale 1ns / 1ps
// slpf_front: sample intake, raster counters, two line stores and the end-of-frame sweep
// emits one neighbourhood record per tested cell; depends on slpf_pkg

module slpf_front #(
	parameter int MAX_COLS    = slpf_pkg::MAX_COLS_DEF,
	parameter int SAMPLE_BITS = slpf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       clear,
	input  logic [slpf_pkg::CFG_W-1:0]                 frame_rows,
	input  logic [slpf_pkg::CFG_W-1:0]                 frame_cols,
	input  logic                                       push,
	output logic                                       full,
	input  logic signed [SAMPLE_BITS-1:0]              sample,
	input  logic                                       frame_end,
	input  logic [slpf_pkg::REC_Q_CNT_W-1:0]           q_count,
	output logic                                       rec_push,
	output slpf_pkg::rec_flags_t                       rec_flags,
	output logic signed [SAMPLE_BITS-1:0]              rec_val,
	output logic signed [SAMPLE_BITS-1:0]              rec_top,
	output logic signed [SAMPLE_BITS-1:0]              rec_bot,
	output logic [slpf_pkg::ROW_W-1:0]                 rec_row,
	output logic [slpf_pkg::idx_w(MAX_COLS)-1:0]       rec_col
);
	import slpf_pkg::*;

	localparam int COL_W = idx_w(MAX_COLS);
	localparam int CNT_W = $clog2(MAX_COLS + 1);

	typedef enum logic [2:0] {
		ST_RUN       = 3'b001,
		ST_FLUSH_UP  = 3'b010,
		ST_FLUSH_LOW = 3'b100
	} fe_state_t;

	fe_state_t                    state_q;
	logic [ROW_W-1:0]             row_q;
	logic [COL_W-1:0]             col_q;
	logic [ROW_W-1:0]             fl_row_q;
	logic [COL_W-1:0]             fl_col_q;
	logic [COL_W-1:0]             fl_end_col_q;
	logic                         sel_q;

	logic signed [SAMPLE_BITS-1:0] line_a [MAX_COLS];
	logic signed [SAMPLE_BITS-1:0] line_b [MAX_COLS];
	logic signed [SAMPLE_BITS-1:0] rd_a_q;
	logic signed [SAMPLE_BITS-1:0] rd_b_q;

	logic                          s2_push_q;
	logic                          s2_sel_q;
	logic                          s2_swap_q;
	rec_flags_t                    s2_flags_q;
	logic signed [SAMPLE_BITS-1:0] s2_bot_q;
	logic [ROW_W-1:0]              s2_row_q;
	logic [COL_W-1:0]              s2_col_q;

	logic [CNT_W-1:0]              cols_eff;
	logic [CFG_W-1:0]              rows_eff;
	logic [COL_W-1:0]              col_last;
	logic [ROW_W-1:0]              row_last;
	logic                          room;
	logic                          accept;
	logic                          flush_issue;
	logic                          is_row_end;
	logic                          end_now;
	logic [COL_W-1:0]              rd_addr;
	logic signed [SAMPLE_BITS-1:0] newer_rd;
	logic signed [SAMPLE_BITS-1:0] older_rd;

	// geometry clamp
	always_comb begin
		if (frame_cols == '0) cols_eff = CNT_W'(1);
		else if (32'(frame_cols) > MAX_COLS) cols_eff = CNT_W'(MAX_COLS);
		else cols_eff = CNT_W'(frame_cols);
		if (frame_rows == '0) rows_eff = CFG_W'(1);
		else if (32'(frame_rows) > ROWS_LIMIT) rows_eff = CFG_W'(ROWS_LIMIT);
		else rows_eff = frame_rows;
	end

	assign col_last = COL_W'(cols_eff - CNT_W'(1));
	assign row_last = ROW_W'(rows_eff - CFG_W'(1));

	assign room        = (int'(q_count) + int'(s2_push_q)) < REC_Q_DEPTH;
	assign full        = (state_q != ST_RUN) || !room;
	assign accept      = push && !full;
	assign flush_issue = (state_q != ST_RUN) && room;
	assign is_row_end  = (col_q == col_last);
	assign end_now     = frame_end || ((row_q == row_last) && is_row_end);
	assign rd_addr     = (state_q == ST_RUN) ? col_q : fl_col_q;

	// sel_q low: line_a holds the newer row, line_b the older
	always_ff @(posedge clk) begin
		if (accept && sel_q) begin
			line_a[col_q] <= sample;
		end
		if (accept || flush_issue) begin
			rd_a_q <= line_a[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !sel_q) begin
			line_b[col_q] <= sample;
		end
		if (accept || flush_issue) begin
			rd_b_q <= line_b[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			row_q        <= '0;
			col_q        <= '0;
			fl_row_q     <= '0;
			fl_col_q     <= '0;
			fl_end_col_q <= '0;
			sel_q        <= 1'b0;
		end else if (clear) begin
			state_q <= ST_RUN;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (accept) begin
						if (end_now) begin
							row_q        <= '0;
							col_q        <= '0;
							fl_row_q     <= row_q;
							fl_end_col_q <= col_q;
							if ((row_q != '0) && !is_row_end) begin
								state_q  <= ST_FLUSH_UP;
								fl_col_q <= col_q + 1'b1;
							end else begin
								state_q  <= ST_FLUSH_LOW;
								fl_col_q <= '0;
							end
						end else if (is_row_end) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
							sel_q <= !sel_q;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_FLUSH_UP: begin
					if (flush_issue) begin
						if (fl_col_q == col_last) begin
							state_q  <= ST_FLUSH_LOW;
							fl_col_q <= '0;
						end else begin
							fl_col_q <= fl_col_q + 1'b1;
						end
					end
				end
				ST_FLUSH_LOW: begin
					if (flush_issue) begin
						if (fl_col_q == fl_end_col_q) state_q <= ST_RUN;
						else fl_col_q <= fl_col_q + 1'b1;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_push_q <= 1'b0;
		end else if (clear) begin
			s2_push_q <= 1'b0;
		end else if (accept) begin
			s2_push_q <= (row_q != '0);
		end else begin
			s2_push_q <= flush_issue;
		end
	end

	// record fields for the beat read out of the line stores
	always_ff @(posedge clk) begin
		if (accept) begin
			s2_sel_q             <= sel_q;
			s2_swap_q            <= 1'b0;
			s2_flags_q.first     <= (col_q == '0);
			s2_flags_q.last      <= is_row_end;
			s2_flags_q.frame_end <= 1'b0;
			s2_flags_q.top_low   <= (row_q < ROW_W'(2));
			s2_flags_q.bot_low   <= 1'b0;
			s2_bot_q             <= sample;
			s2_row_q             <= row_q - 1'b1;
			s2_col_q             <= col_q;
		end else if (flush_issue) begin
			s2_sel_q <= sel_q;
			s2_bot_q <= '0;
			s2_col_q <= fl_col_q;
			s2_flags_q.bot_low <= 1'b1;
			if (state_q == ST_FLUSH_UP) begin
				s2_swap_q            <= 1'b0;
				s2_flags_q.first     <= 1'b0;
				s2_flags_q.last      <= (fl_col_q == col_last);
				s2_flags_q.frame_end <= 1'b0;
				s2_flags_q.top_low   <= (fl_row_q < ROW_W'(2));
				s2_row_q             <= fl_row_q - 1'b1;
			end else begin
				s2_swap_q            <= 1'b1;
				s2_flags_q.first     <= (fl_col_q == '0);
				s2_flags_q.last      <= (fl_col_q == fl_end_col_q);
				s2_flags_q.frame_end <= (fl_col_q == fl_end_col_q);
				s2_flags_q.top_low   <= (fl_row_q == '0);
				s2_row_q             <= fl_row_q;
			end
		end
	end

	assign newer_rd  = s2_sel_q ? rd_b_q : rd_a_q;
	assign older_rd  = s2_sel_q ? rd_a_q : rd_b_q;
	assign rec_push  = s2_push_q;
	assign rec_flags = s2_flags_q;
	assign rec_val   = s2_swap_q ? older_rd : newer_rd;
	assign rec_top   = s2_swap_q ? newer_rd : older_rd;
	assign rec_bot   = s2_bot_q;
	assign rec_row   = s2_row_q;
	assign rec_col   = s2_col_q;

endmodule

### rtl/slpf_back.sv
`timescale 1ns / 1ps
// slpf_back: sliding left/right window over records, peak test and smallest-peak tracking
// pushes one result per frame; depends on slpf_pkg

module slpf_back #(
	parameter int MAX_COLS    = slpf_pkg::MAX_COLS_DEF,
	parameter int SAMPLE_BITS = slpf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clear,
	input  logic                                   rec_valid,
	output logic                                   rec_pop,
	input  slpf_pkg::rec_flags_t                   rec_flags,
	input  logic signed [SAMPLE_BITS-1:0]          rec_val,
	input  logic signed [SAMPLE_BITS-1:0]          rec_top,
	input  logic signed [SAMPLE_BITS-1:0]          rec_bot,
	input  logic [slpf_pkg::ROW_W-1:0]             rec_row,
	input  logic [slpf_pkg::idx_w(MAX_COLS)-1:0]   rec_col,
	input  logic [slpf_pkg::RES_Q_CNT_W-1:0]       res_count,
	output logic                                   res_push,
	output logic                                   res_found,
	output logic [slpf_pkg::ROW_W-1:0]             res_row,
	output logic [slpf_pkg::POS_W-1:0]             res_col
);
	import slpf_pkg::*;

	localparam int COL_W = idx_w(MAX_COLS);

	logic                          pend_valid_q;
	logic signed [SAMPLE_BITS-1:0] pend_val_q;
	logic signed [SAMPLE_BITS-1:0] pend_top_q;
	logic signed [SAMPLE_BITS-1:0] pend_bot_q;
	logic signed [SAMPLE_BITS-1:0] pend_left_q;
	logic                          pend_top_low_q;
	logic                          pend_bot_low_q;
	logic                          pend_left_low_q;
	logic [ROW_W-1:0]              pend_row_q;
	logic [COL_W-1:0]              pend_col_q;

	logic                          s1_valid_q;
	logic                          s1_end_q;
	logic                          s1_cand_q;
	logic signed [SAMPLE_BITS-1:0] s1_val_q;
	logic [ROW_W-1:0]              s1_row_q;
	logic [COL_W-1:0]              s1_col_q;

	logic                          found_q;
	logic signed [SAMPLE_BITS-1:0] best_val_q;
	logic [ROW_W-1:0]              best_row_q;
	logic [COL_W-1:0]              best_col_q;

	logic                          p_peak;
	logic                          n_peak;
	logic                          n_left_low;
	logic                          take_n;
	logic                          upd;
	logic [ROW_W-1:0]              nxt_row;
	logic [COL_W-1:0]              nxt_col;
	logic [COL_W+POS_W-1:0]        col_ext;

	assign rec_pop = rec_valid && (!rec_flags.frame_end ||
		((int'(res_count) + int'(s1_end_q)) < RES_Q_DEPTH));

	// pending cell gets its right neighbour from the incoming beat
	assign p_peak = pend_valid_q
		&& (pend_top_low_q || (pend_val_q > pend_top_q))
		&& (pend_bot_low_q || (pend_val_q > pend_bot_q))
		&& (pend_left_low_q || (pend_val_q > pend_left_q))
		&& (pend_val_q > rec_val);

	// a row-closing beat is tested at once, right neighbour outside
	assign n_left_low = rec_flags.first || !pend_valid_q;
	assign n_peak = rec_flags.last
		&& (rec_flags.top_low || (rec_val > rec_top))
		&& (rec_flags.bot_low || (rec_val > rec_bot))
		&& (n_left_low || (rec_val > pend_val_q));
	assign take_n = n_peak && (!p_peak || (rec_val < pend_val_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			s1_valid_q   <= 1'b0;
			s1_end_q     <= 1'b0;
		end else if (clear) begin
			pend_valid_q <= 1'b0;
			s1_valid_q   <= 1'b0;
			s1_end_q     <= 1'b0;
		end else begin
			s1_valid_q <= rec_pop;
			s1_end_q   <= rec_pop && rec_flags.frame_end;
			if (rec_pop) begin
				pend_valid_q <= !rec_flags.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			pend_val_q      <= rec_val;
			pend_top_q      <= rec_top;
			pend_bot_q      <= rec_bot;
			pend_left_q     <= pend_val_q;
			pend_top_low_q  <= rec_flags.top_low;
			pend_bot_low_q  <= rec_flags.bot_low;
			pend_left_low_q <= n_left_low;
			pend_row_q      <= rec_row;
			pend_col_q      <= rec_col;
			s1_cand_q       <= p_peak || n_peak;
			s1_val_q        <= take_n ? rec_val : pend_val_q;
			s1_row_q        <= take_n ? rec_row : pend_row_q;
			s1_col_q        <= take_n ? rec_col : pend_col_q;
		end
	end

	assign upd     = s1_valid_q && s1_cand_q && (!found_q || (s1_val_q < best_val_q));
	assign nxt_row = upd ? s1_row_q : best_row_q;
	assign nxt_col = upd ? s1_col_q : best_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (clear || (s1_valid_q && s1_end_q)) begin
			found_q    <= 1'b0;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (upd) begin
			found_q    <= 1'b1;
			best_row_q <= s1_row_q;
			best_col_q <= s1_col_q;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			best_val_q <= s1_val_q;
		end
	end

	assign col_ext   = {{POS_W{1'b0}}, nxt_col};
	assign res_push  = s1_valid_q && s1_end_q;
	assign res_found = found_q || upd;
	assign res_row   = nxt_row;
	assign res_col   = col_ext[POS_W-1:0];

endmodule

### rtl/smallest_local_peak_finder_core.sv
`timescale 1ns / 1ps
// smallest_local_peak_finder_core: top level, configuration registers and the two queues
// depends on slpf_pkg, slpf_front, slpf_fifo and slpf_back

// Finds the smallest 4-neighbour local maximum of a raster frame of signed samples and
// reports its row and column once per frame. While a frame streams and full is low, one
// sample is taken every clock. After the last sample of a frame full stays high while the
// line stores are swept column by column through their one read port each to test the
// bottom row: every column of the clamped frame width when the frame reached its second
// row, otherwise as many columns as it had samples. The result goes through the record
// queue, the back end's stage-one register and the result queue to empty/peak_row/peak_col.
// A result waiting to be popped does not hold up the next frame's samples unless both
// result slots are taken. Writing either geometry register drops the frame in progress.

module smallest_local_peak_finder_core #(
	parameter int MAX_COLS    = slpf_pkg::MAX_COLS_DEF,
	parameter int SAMPLE_BITS = slpf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [slpf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [slpf_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 frame_end,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 found,
	output logic [slpf_pkg::ROW_W-1:0]           peak_row,
	output logic [slpf_pkg::POS_W-1:0]           peak_col
);
	import slpf_pkg::*;

	localparam int COL_W = idx_w(MAX_COLS);
	localparam int REC_W = REC_FLAGS_W + 3 * SAMPLE_BITS + ROW_W + COL_W;

	logic [CFG_W-1:0]              frame_rows_q;
	logic [CFG_W-1:0]              frame_cols_q;
	logic                          cfg_clear;

	logic                          fe_push;
	rec_flags_t                    fe_flags;
	logic signed [SAMPLE_BITS-1:0] fe_val;
	logic signed [SAMPLE_BITS-1:0] fe_top;
	logic signed [SAMPLE_BITS-1:0] fe_bot;
	logic [ROW_W-1:0]              fe_row;
	logic [COL_W-1:0]              fe_col;

	logic [REC_W-1:0]              q_wdata;
	logic [REC_W-1:0]              q_rdata;
	logic                          q_empty;
	logic [REC_Q_CNT_W-1:0]        q_count;

	rec_flags_t                    bk_flags;
	logic signed [SAMPLE_BITS-1:0] bk_val;
	logic signed [SAMPLE_BITS-1:0] bk_top;
	logic signed [SAMPLE_BITS-1:0] bk_bot;
	logic [ROW_W-1:0]              bk_row;
	logic [COL_W-1:0]              bk_col;
	logic                          bk_pop;

	logic                          res_push;
	logic                          res_found;
	logic [ROW_W-1:0]              res_row;
	logic [POS_W-1:0]              res_col;
	logic [RES_W-1:0]              res_rdata;
	logic [RES_Q_CNT_W-1:0]        res_count;

	assign cfg_clear = cfg_we && ((cfg_addr == REG_FRAME_ROWS) || (cfg_addr == REG_FRAME_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= CFG_W'(1);
			frame_cols_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FRAME_ROWS: frame_rows_q <= cfg_wdata;
				REG_FRAME_COLS: frame_cols_q <= cfg_wdata;
				default: frame_rows_q <= frame_rows_q;
			endcase
		end
	end

	slpf_front #(
		.MAX_COLS    (MAX_COLS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_clear),
		.frame_rows (frame_rows_q),
		.frame_cols (frame_cols_q),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.frame_end  (frame_end),
		.q_count    (q_count),
		.rec_push   (fe_push),
		.rec_flags  (fe_flags),
		.rec_val    (fe_val),
		.rec_top    (fe_top),
		.rec_bot    (fe_bot),
		.rec_row    (fe_row),
		.rec_col    (fe_col)
	);

	assign q_wdata = {fe_flags, fe_val, fe_top, fe_bot, fe_row, fe_col};

	slpf_fifo #(
		.WIDTH (REC_W),
		.DEPTH (REC_Q_DEPTH)
	) u_rec_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.pop    (bk_pop),
		.wdata  (q_wdata),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  (q_count)
	);

	assign {bk_flags, bk_val, bk_top, bk_bot, bk_row, bk_col} = q_rdata;

	slpf_back #(
		.MAX_COLS    (MAX_COLS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_clear),
		.rec_valid (!q_empty),
		.rec_pop   (bk_pop),
		.rec_flags (bk_flags),
		.rec_val   (bk_val),
		.rec_top   (bk_top),
		.rec_bot   (bk_bot),
		.rec_row   (bk_row),
		.rec_col   (bk_col),
		.res_count (res_count),
		.res_push  (res_push),
		.res_found (res_found),
		.res_row   (res_row),
		.res_col   (res_col)
	);

	slpf_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.pop    (pop),
		.wdata  ({res_found, res_row, res_col}),
		.rdata  (res_rdata),
		.empty  (empty),
		.count  (res_count)
	);

	assign {found, peak_row, peak_col} = res_rdata;

endmodule

### rtl/slpf_chk.sv
`timescale 1ns / 1ps
// slpf_chk: port-level checks on the peak finder result side and full flag, bound to the top level
// depends on slpf_pkg and smallest_local_peak_finder_core

module slpf_chk #(
	parameter int MAX_COLS = slpf_pkg::MAX_COLS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        full,
	input logic                        empty,
	input logic                        pop,
	input logic                        found,
	input logic [slpf_pkg::ROW_W-1:0]  peak_row,
	input logic [slpf_pkg::POS_W-1:0]  peak_col
);

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("result or input side busy during reset");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(found) && $stable(peak_row) && $stable(peak_col))
		else $error("waiting result beat changed");

	a_none_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !found |-> (peak_row == '0) && (peak_col == '0))
		else $error("position not zero on a frame without peak");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && found |-> (32'(peak_col) < MAX_COLS))
		else $error("peak column outside line store");

endmodule

bind smallest_local_peak_finder_core slpf_chk #(
	.MAX_COLS (MAX_COLS)
) u_slpf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.found    (found),
	.peak_row (peak_row),
	.peak_col (peak_col)
);

### sim/peak_checker.sv
`timescale 1ns / 1ps
// peak_checker: watches the register, sample and result ports of the peak finder, predicts
// the smallest 4-neighbour peak of every frame and checks each result beat against it
// depends on slpf_pkg

module peak_checker (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [slpf_pkg::CFG_ADDR_W-1:0]           cfg_addr,
	input  logic [slpf_pkg::CFG_W-1:0]                cfg_wdata,
	input  logic                                      push,
	input  logic                                      full,
	input  logic signed [slpf_pkg::SAMPLE_BITS_DEF-1:0] sample,
	input  logic                                      frame_end,
	input  logic                                      empty,
	input  logic                                      pop,
	input  logic                                      found,
	input  logic [slpf_pkg::ROW_W-1:0]                peak_row,
	input  logic [slpf_pkg::POS_W-1:0]                peak_col,
	output int                                        waiting,
	output int                                        errors
);
	import slpf_pkg::*;

	// lower than any sample, stands for positions outside the frame
	localparam int BELOW_ALL = -(1 << 30);

	typedef struct {
		logic             found;
		logic [ROW_W-1:0] row;
		logic [POS_W-1:0] col;
	} peak_t;

	peak_t peak_expect_q[$];
	peak_t oldest;
	int    line_back1[MAX_COLS_DEF];
	int    line_back2[MAX_COLS_DEF];
	int    best_val;
	int    best_r;
	int    best_c;
	bit    have_peak;
	int    cur_r;
	int    cur_c;
	int    geo_rows = 1;
	int    geo_cols = 1;
	int    fail_count = 0;

	assign errors = fail_count;

	function automatic int clamp_dim(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int back1_at(int idx, int len);
		return (idx < 0 || idx >= len) ? BELOW_ALL : line_back1[idx];
	endfunction

	function automatic int back2_at(int idx, int len);
		return (idx < 0 || idx >= len) ? BELOW_ALL : line_back2[idx];
	endfunction

	task automatic rate_cell(int v, int up, int down, int left, int right, int row, int col);
		if (v > up && v > down && v > left && v > right && (!have_peak || v < best_val)) begin
			best_val  = v;
			best_r    = row;
			best_c    = col;
			have_peak = 1'b1;
		end
	endtask

	task automatic clear_frame();
		have_peak = 1'b0;
		best_val  = 0;
		best_r    = 0;
		best_c    = 0;
		cur_r     = 0;
		cur_c     = 0;
	endtask

	task automatic take_sample(int s, bit fe);
		int    cols;
		int    rows;
		int    r;
		int    c;
		int    len;
		int    k;
		int    tmp;
		bit    done;
		peak_t res;
		cols = clamp_dim(geo_cols, MAX_COLS_DEF);
		rows = clamp_dim(geo_rows, ROWS_LIMIT);
		if (cur_c >= cols)
			cur_c = 0;
		r = cur_r;
		c = cur_c;
		// the cell above is complete once the sample below it arrives
		if (r >= 1)
			rate_cell(line_back1[c], (r >= 2) ? line_back2[c] : BELOW_ALL, s,
				back1_at(c - 1, cols), back1_at(c + 1, cols), r - 1, c);
		line_back2[c] = s;
		done = fe || (r == rows - 1 && c == cols - 1);
		if (done) begin
			len = c + 1;
			// rest of the row above, nothing below it
			if (r >= 1) begin
				for (k = len; k < cols; k++)
					rate_cell(line_back1[k], (r >= 2) ? line_back2[k] : BELOW_ALL, BELOW_ALL,
						back1_at(k - 1, cols), back1_at(k + 1, cols), r - 1, k);
			end
			// last row, cut at the final sample
			for (k = 0; k < len; k++)
				rate_cell(line_back2[k], (r >= 1) ? line_back1[k] : BELOW_ALL, BELOW_ALL,
					back2_at(k - 1, len), back2_at(k + 1, len), r, k);
			res.found = have_peak;
			res.row   = have_peak ? best_r[ROW_W-1:0] : '0;
			res.col   = have_peak ? best_c[POS_W-1:0] : '0;
			peak_expect_q.push_back(res);
			clear_frame();
		end else if (c == cols - 1) begin
			for (k = 0; k < cols; k++) begin
				tmp           = line_back2[k];
				line_back2[k] = line_back1[k];
				line_back1[k] = tmp;
			end
			cur_c = 0;
			cur_r = r + 1;
		end else begin
			cur_c = c + 1;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (peak_expect_q.size() == 0) begin
					fail_count++;
					$error("result beat with no frame pending: found %0b row %0d col %0d",
						found, peak_row, peak_col);
				end else begin
					oldest = peak_expect_q.pop_front();
					if (found !== oldest.found) begin
						fail_count++;
						$error("found: expected %0b, got %0b", oldest.found, found);
					end
					if (peak_row !== oldest.row) begin
						fail_count++;
						$error("peak_row: expected %0d, got %0d", oldest.row, peak_row);
					end
					if (peak_col !== oldest.col) begin
						fail_count++;
						$error("peak_col: expected %0d, got %0d", oldest.col, peak_col);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_addr == REG_FRAME_ROWS)
					geo_rows = cfg_wdata;
				else if (cfg_addr == REG_FRAME_COLS)
					geo_cols = cfg_wdata;
				clear_frame();
			end
			if (push && !full)
				take_sample(sample, frame_end);
			waiting <= peak_expect_q.size();
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset, register writes and sample stimulus for the peak finder, and verdict
// depends on slpf_pkg, peak_checker and smallest_local_peak_finder_core

module tb_top;
	import slpf_pkg::*;

	localparam int SW           = SAMPLE_BITS_DEF;
	localparam int RUN_LIMIT    = 1500000;
	localparam int DRAIN_CYCLES = 1100;
	localparam int RANDOM_ITEMS = 1600;
	localparam int EARLY_CAP    = 40;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = REG_FRAME_ROWS;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  push      = 1'b0;
	logic                  full;
	logic signed [SW-1:0]  sample    = '0;
	logic                  frame_end = 1'b0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic                  found;
	logic [ROW_W-1:0]      peak_row;
	logic [POS_W-1:0]      peak_col;
	int                    waiting;
	int                    errors;
	bit                    calm      = 1'b0;
	int                    rows_eff  = 1;
	int                    cols_eff  = 1;
	int                    sent      = 0;
	int                    cycles    = 0;

	always #5 clk = ~clk;

	smallest_local_peak_finder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop),
		.found     (found),
		.peak_row  (peak_row),
		.peak_col  (peak_col)
	);

	peak_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop),
		.found     (found),
		.peak_row  (peak_row),
		.peak_col  (peak_col),
		.waiting   (waiting),
		.errors    (errors)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// result side: random stall bursts, steady pop near the end
	initial begin
		@(posedge arst_n);
		forever begin
			if (calm) begin
				pop <= 1'b1;
				@(posedge clk);
			end else begin
				pop <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	function automatic int eff(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic signed [SW-1:0] pick(int mode, int r, int c);
		case (mode)
			0: return SW'($urandom);
			1: return SW'($urandom_range(0, 6) - 3);
			2: begin
				case ($urandom_range(0, 2))
					0:       return 16'sh7FFF;
					1:       return 16'sh8000;
					default: return SW'($urandom_range(0, 1));
				endcase
			end
			default: return SW'(r * 5 - c * 3 + $urandom_range(0, 2));
		endcase
	endfunction

	task automatic pause_push();
		if (!calm && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send(input logic signed [SW-1:0] s, input bit fe);
		pause_push();
		push      <= 1'b1;
		sample    <= s;
		frame_end <= fe;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_results();
		push <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
	endtask

	task automatic drain();
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int v);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input int rows, input int cols);
		drain();
		write_reg(REG_FRAME_ROWS, rows);
		write_reg(REG_FRAME_COLS, cols);
		rows_eff = eff(rows, ROWS_LIMIT);
		cols_eff = eff(cols, MAX_COLS_DEF);
	endtask

	// early: frame_end within the first EARLY_CAP samples, on or before the last position; cut: stop without any frame end
	task automatic send_frame(input int mode, input bit early, input bit cut);
		int total;
		int count;
		int lim;
		int k;
		bit fe;
		total = rows_eff * cols_eff;
		count = total;
		if (cut) begin
			lim   = (total - 1 < EARLY_CAP) ? total - 1 : EARLY_CAP;
			count = (lim >= 1) ? $urandom_range(1, lim) : 0;
		end else if (early) begin
			lim   = (total < EARLY_CAP) ? total : EARLY_CAP;
			count = $urandom_range(1, lim);
		end
		for (k = 0; k < count; k++) begin
			fe = (k == count - 1) && !cut && (early || $urandom_range(0, 1) == 1);
			send(pick(mode, k / cols_eff, k % cols_eff), fe);
		end
	endtask

	initial begin
		int k;
		int n;
		int frames;
		bit early;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one by one geometry after reset: every sample is its own frame
		send(16'sd5, 1'b0);
		send(16'sh7FFF, 1'b1);
		send(16'sh8000, 1'b0);
		set_geometry(0, 0);
		send(16'sh0000, 1'b0);

		// corners at 1 tie, centre at 2 is a larger peak
		set_geometry(3, 3);
		for (k = 0; k < 9; k++)
			send((k % 2 == 1) ? 16'sd0 : ((k == 4) ? 16'sd2 : 16'sd1), 1'b0);
		// frame ended in the middle of the second row
		for (k = 0; k < 5; k++)
			send(pick(0, 0, 0), k == 4);
		// partial frame dropped by the next register write
		send(pick(1, 0, 0), 1'b0);
		send(pick(1, 0, 0), 1'b0);
		set_geometry(2047, 2047);
		for (k = 0; k < 3; k++)
			send(pick(1, 0, 0), k == 2);

		// full width: rising first row, short second row of minimum samples
		set_geometry(2047, 1024);
		for (k = 0; k < 1024; k++)
			send(SW'(k - 600), 1'b0);
		n = $urandom_range(1, EARLY_CAP);
		for (k = 0; k < n; k++)
			send(16'sh8000, k == n - 1);

		// full height, single column, ends on its own at the last row
		set_geometry(1024, 1);
		for (k = 0; k < 1024; k++)
			send(SW'(k * 3 - 1500), 1'b0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent > RANDOM_ITEMS * 7 / 8)
				calm = 1'b1;
			case ($urandom_range(0, 7))
				0:       set_geometry($urandom_range(0, 3), $urandom_range(1025, 2047));
				1:       set_geometry($urandom_range(1, 3), $urandom_range(11, 40));
				2:       set_geometry($urandom_range(1025, 2047), $urandom_range(0, 6));
				default: set_geometry($urandom_range(1, 6), $urandom_range(1, 10));
			endcase
			frames = $urandom_range(3, 12);
			for (n = 0; n < frames; n++) begin
				if (!calm && $urandom_range(0, 5) == 0)
					wait_results();
				early = (rows_eff * cols_eff > 64) || ($urandom_range(0, 3) == 0);
				send_frame($urandom_range(0, 3), early, 1'b0);
			end
			if ($urandom_range(0, 5) == 0)
				send_frame($urandom_range(0, 3), 1'b0, 1'b1);
		end

		drain();
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

### files.f
rtl/slpf_pkg.sv
rtl/slpf_fifo.sv
rtl/slpf_front.sv
rtl/slpf_back.sv
rtl/smallest_local_peak_finder_core.sv
rtl/slpf_chk.sv
sim/peak_checker.sv
sim/tb_top.sv
